>>> sv/pte_pkg.sv
// shared widths, codes, types and saturation helper for the spline evaluator
package pte_pkg;

   localparam int MAX_KNOTS  = 64;
   localparam int MAX_DEGREE = 8;
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int KNOT_W     = $clog2(MAX_KNOTS);
   localparam int DSLOT_W    = $clog2(MAX_DEGREE);
   localparam int DADDR_W    = KNOT_W + DSLOT_W;
   localparam int DIV_W      = 48;
   localparam int DVS_W      = 34;
   localparam int DCNT_W     = $clog2(DIV_W);

   localparam logic [1:0] MODE_LOAD_KNOT  = 2'd0;
   localparam logic [1:0] MODE_LOAD_DERIV = 2'd1;
   localparam logic [1:0] MODE_EVAL       = 2'd2;

   localparam logic [3:0] CSR_DEGREE = 4'd0;
   localparam logic [3:0] CSR_KNOTS  = 4'd1;

   localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;

   typedef struct packed {
      logic                    start;
      logic [DIV_W-1:0]        dividend;
      logic [DVS_W-1:0]        divisor;
   } pte_div_req_type;

   typedef struct packed {
      logic                    done;
      logic [DIV_W-1:0]        quotient;
      logic [DVS_W-1:0]        remainder;
   } pte_div_rsp_type;

   typedef struct packed {
      logic                         clip;
      logic signed [DATA_WIDTH-1:0] value;
   } pte_sat_type;

   function automatic pte_sat_type pte_sat(input logic signed [63:0] v);
      pte_sat_type r;
      r.clip = 1'b0;
      if (v > SAT_MAX) begin
         r.clip  = 1'b1;
         r.value = SAT_MAX[DATA_WIDTH-1:0];
      end else if (v < SAT_MIN) begin
         r.clip  = 1'b1;
         r.value = SAT_MIN[DATA_WIDTH-1:0];
      end else begin
         r.value = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

>>> sv/pte_if.sv
// valid/ready channel interfaces for request, response and register writes
interface pte_req_if;
   import pte_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic [KNOT_W-1:0]            knot_slot;
   logic [DSLOT_W-1:0]           deriv_slot;
   logic signed [DATA_WIDTH-1:0] load_x;
   logic signed [DATA_WIDTH-1:0] load_value;
   logic signed [DATA_WIDTH-1:0] sample_x;
   logic [3:0]                   deriv_order;
   modport source (output valid, mode, knot_slot, deriv_slot, load_x, load_value,
                   sample_x, deriv_order, input ready);
   modport sink (input valid, mode, knot_slot, deriv_slot, load_x, load_value,
                 sample_x, deriv_order, output ready);
endinterface

interface pte_rsp_if;
   import pte_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic [KNOT_W-1:0]            segment_index;
   logic                         saturated;
   logic                         wrapped;
   modport source (output valid, result_value, segment_index, saturated, wrapped,
                   input ready);
   modport sink (input valid, result_value, segment_index, saturated, wrapped,
                 output ready);
endinterface

interface pte_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/pte_divider.sv
// shared restoring divider, one quotient bit per cycle, unsigned magnitudes
module pte_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  pte_pkg::pte_div_req_type div_req,
   output pte_pkg::pte_div_rsp_type div_rsp
);
   import pte_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [DVS_W:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]    quot_ff, quot_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic [DVS_W:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[DVS_W-1:0], quot_ff[DIV_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff[DVS_W-1:0];

endmodule

>>> sv/piecewise_taylor_spline_eval_core.sv
// top level: knot tables, segment search and Horner sequencer of the spline evaluator
//
// req_ch carries one word per item: mode 0 writes knot x and y, mode 1 writes one
// derivative, mode 2 evaluates at sample_x, mode 3 is dropped. Loads give no
// response word. Each evaluation gives one word on rsp_ch.
// csr_ch writes spline_degree (index 0) and knot_count (index 1); always ready.
// Evaluation reads the tables and compares, then may check the segment hint and
// run up to six search probes, then runs one divider pass per Horner term
// (p - k terms), with one more pass on the cyclic path when the span is nonzero.
// Both the wrap remainder and the per-term division run on one shared divider of
// 48 one-bit steps. An order above the degree goes straight to a zero result.
// req_ch is ready only while the sequencer is idle; one item is in work at a time.
// A finished result sits in the output register until rsp_ch takes it; the next
// item is accepted meanwhile, and a further evaluation waits at its end.
// Reset (synchronous) clears control state, the segment hint and the registers to
// degree 3 and two knots; the knot tables hold unknown data until written.
module piecewise_taylor_spline_eval_core (
   input logic clock,
   input logic reset,
   pte_req_if.sink   req_ch,
   pte_rsp_if.source rsp_ch,
   pte_csr_if.sink   csr_ch
);
   import pte_pkg::*;

   localparam logic [4:0] ST_IDLE       = 5'd0;
   localparam logic [4:0] ST_FETCH_LAST = 5'd1;
   localparam logic [4:0] ST_CLASSIFY   = 5'd2;
   localparam logic [4:0] ST_WRAP_WAIT  = 5'd3;
   localparam logic [4:0] ST_SEARCH     = 5'd4;
   localparam logic [4:0] ST_HINT_A     = 5'd5;
   localparam logic [4:0] ST_HINT_B     = 5'd6;
   localparam logic [4:0] ST_SRCH_RD    = 5'd7;
   localparam logic [4:0] ST_SRCH_CMP   = 5'd8;
   localparam logic [4:0] ST_DELTA_RD   = 5'd9;
   localparam logic [4:0] ST_DELTA      = 5'd10;
   localparam logic [4:0] ST_H_RD       = 5'd11;
   localparam logic [4:0] ST_H_ACC      = 5'd12;
   localparam logic [4:0] ST_H_MUL      = 5'd13;
   localparam logic [4:0] ST_H_DIV      = 5'd14;
   localparam logic [4:0] ST_H_WAIT     = 5'd15;
   localparam logic [4:0] ST_BASE       = 5'd16;
   localparam logic [4:0] ST_OUT        = 5'd17;

   localparam int N_W = KNOT_W + 1;
   localparam int XV_W = DATA_WIDTH + 3;

   logic signed [DATA_WIDTH-1:0] x_mem [MAX_KNOTS];
   logic signed [DATA_WIDTH-1:0] y_mem [MAX_KNOTS];
   logic signed [DATA_WIDTH-1:0] d_mem [MAX_KNOTS*MAX_DEGREE];
   logic signed [DATA_WIDTH-1:0] x_rd_ff, y_rd_ff, d_rd_ff;
   logic [KNOT_W-1:0]  x_ra, y_ra;
   logic [DADDR_W-1:0] d_ra;

   logic [4:0]  state_ff, state_in;
   logic [3:0]  degree_ff;
   logic [N_W-1:0] knots_ff;
   logic [KNOT_W-1:0] hint_ff, hint_in;
   logic signed [XV_W-1:0] xv_ff, xv_in;
   logic [3:0]  k_ff, k_in;
   logic [3:0]  j_ff, j_in;
   logic signed [DATA_WIDTH-1:0] x0_ff, x0_in, y0_ff, y0_in, xh_ff, xh_in;
   logic signed [DATA_WIDTH-1:0] delta_ff, delta_in, sum_ff, sum_in, acc_ff, acc_in;
   logic signed [2*DATA_WIDTH-1:0] prod_ff, prod_in;
   logic [KNOT_W-1:0] seg_ff, seg_in;
   logic [N_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic        neg_ff, neg_in, flag_ff, flag_in, wrap_ff, wrap_in;

   logic        out_valid_ff, out_valid_in;
   logic signed [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   logic [KNOT_W-1:0] out_seg_ff, out_seg_in;
   logic        out_sat_ff, out_sat_in, out_wrap_ff, out_wrap_in;

   logic [3:0]     p_eff;
   logic [N_W-1:0] n_eff;
   logic [KNOT_W-1:0] last_idx, mid;
   logic req_fire;
   logic signed [DATA_WIDTH:0] span, diff;
   logic signed [63:0] wide;
   logic [2*DATA_WIDTH-1:0] prod_mag;
   pte_sat_type sat_r;
   pte_div_req_type div_req;
   pte_div_rsp_type div_rsp;

   pte_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign p_eff = (degree_ff < 4'd1) ? 4'd1 :
                  (degree_ff > 4'(MAX_DEGREE)) ? 4'(MAX_DEGREE) : degree_ff;
   assign n_eff = (knots_ff < N_W'(2)) ? N_W'(2) :
                  (knots_ff > N_W'(MAX_KNOTS)) ? N_W'(MAX_KNOTS) : knots_ff;
   assign last_idx = KNOT_W'(n_eff - N_W'(1));
   assign mid      = KNOT_W'((lo_ff + hi_ff) >> 1);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign span = DATA_WIDTH'(0) + ((DATA_WIDTH+1)'(x_rd_ff) - (DATA_WIDTH+1)'(x0_ff));
   assign diff = (DATA_WIDTH+1)'(xv_ff) - (DATA_WIDTH+1)'(x0_ff);
   assign prod_mag = prod_ff[2*DATA_WIDTH-1] ? (2*DATA_WIDTH)'(-prod_ff) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 4'd3;
         knots_ff  <= N_W'(2);
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_DEGREE: degree_ff <= csr_ch.data[3:0];
            CSR_KNOTS:  knots_ff  <= csr_ch.data[N_W-1:0];
            default: ;
         endcase
      end
   end

   // table read addresses follow the state
   always_comb begin
      x_ra = '0;
      y_ra = '0;
      d_ra = '0;
      unique case (state_ff)
         ST_FETCH_LAST: begin
            x_ra = last_idx;
            y_ra = last_idx;
         end
         ST_SEARCH:   x_ra = hint_ff;
         ST_HINT_A:   x_ra = hint_ff + 1'b1;
         ST_SRCH_RD:  x_ra = mid;
         ST_DELTA_RD: x_ra = seg_ff;
         ST_H_RD: begin
            y_ra = seg_ff;
            if (j_ff > k_ff) d_ra = {seg_ff, DSLOT_W'(j_ff - 4'd1)};
            else d_ra = {seg_ff, DSLOT_W'(k_ff - 4'd1)};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_ch.mode == MODE_LOAD_KNOT) begin
         x_mem[req_ch.knot_slot] <= req_ch.load_x;
         y_mem[req_ch.knot_slot] <= req_ch.load_value;
      end
      if (req_fire && req_ch.mode == MODE_LOAD_DERIV) begin
         d_mem[{req_ch.knot_slot, req_ch.deriv_slot}] <= req_ch.load_value;
      end
      x_rd_ff <= x_mem[x_ra];
      y_rd_ff <= y_mem[y_ra];
      d_rd_ff <= d_mem[d_ra];
   end

   always_comb begin
      state_in = state_ff;
      hint_in  = hint_ff;
      xv_in    = xv_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      x0_in    = x0_ff;
      y0_in    = y0_ff;
      xh_in    = xh_ff;
      delta_in = delta_ff;
      sum_in   = sum_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      seg_in   = seg_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      neg_in   = neg_ff;
      flag_in  = flag_ff;
      wrap_in  = wrap_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_seg_in   = out_seg_ff;
      out_sat_in   = out_sat_ff;
      out_wrap_in  = out_wrap_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      wide  = '0;
      sat_r = pte_sat(wide);
      if (out_valid_ff && rsp_ch.ready) out_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.mode == MODE_EVAL) begin
               xv_in   = XV_W'(req_ch.sample_x);
               k_in    = req_ch.deriv_order;
               flag_in = 1'b0;
               wrap_in = 1'b0;
               sum_in  = '0;
               if (req_ch.deriv_order > p_eff) begin
                  seg_in   = '0;
                  sum_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_FETCH_LAST;
               end
            end
         end
         ST_FETCH_LAST: begin
            x0_in    = x_rd_ff;
            y0_in    = y_rd_ff;
            state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            lo_in = '0;
            hi_in = n_eff;
            if (n_eff > N_W'(3) && y0_ff == y_rd_ff) begin
               wrap_in = 1'b1;
               if (span == '0) begin
                  xv_in    = XV_W'(x0_ff);
                  state_in = ST_SEARCH;
               end else begin
                  neg_in           = diff[DATA_WIDTH];
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(diff[DATA_WIDTH] ? -diff : diff);
                  div_req.divisor  = DVS_W'(span[DATA_WIDTH] ? -span : span);
                  state_in         = ST_WRAP_WAIT;
               end
            end else if (xv_ff <= XV_W'(x0_ff)) begin
               seg_in   = '0;
               state_in = ST_DELTA_RD;
            end else if (xv_ff >= XV_W'(x_rd_ff)) begin
               seg_in   = last_idx;
               state_in = ST_DELTA_RD;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_WRAP_WAIT: begin
            if (div_rsp.done) begin
               if (neg_ff) xv_in = XV_W'(x0_ff) - XV_W'(div_rsp.remainder);
               else xv_in = XV_W'(x0_ff) + XV_W'(div_rsp.remainder);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (N_W'(hint_ff) < N_W'(last_idx)) state_in = ST_HINT_A;
            else state_in = ST_SRCH_RD;
         end
         ST_HINT_A: begin
            xh_in    = x_rd_ff;
            state_in = ST_HINT_B;
         end
         ST_HINT_B: begin
            if (XV_W'(xh_ff) <= xv_ff && xv_ff < XV_W'(x_rd_ff)) begin
               seg_in   = hint_ff;
               state_in = ST_DELTA_RD;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (hi_ff - lo_ff > N_W'(1)) begin
               state_in = ST_SRCH_CMP;
            end else begin
               seg_in   = KNOT_W'(lo_ff);
               state_in = ST_DELTA_RD;
            end
         end
         ST_SRCH_CMP: begin
            if (xv_ff < XV_W'(x_rd_ff)) hi_in = N_W'(mid);
            else lo_in = N_W'(mid);
            state_in = ST_SRCH_RD;
         end
         ST_DELTA_RD: begin
            hint_in  = seg_ff;
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            wide     = 64'(xv_ff) - 64'(x_rd_ff);
            sat_r    = pte_sat(wide);
            delta_in = sat_r.value;
            flag_in  = flag_ff | sat_r.clip;
            j_in     = p_eff;
            sum_in   = '0;
            state_in = ST_H_RD;
         end
         ST_H_RD: begin
            if (j_ff > k_ff) state_in = ST_H_ACC;
            else state_in = ST_BASE;
         end
         ST_H_ACC: begin
            wide     = 64'(sum_ff) + 64'(d_rd_ff);
            sat_r    = pte_sat(wide);
            acc_in   = sat_r.value;
            flag_in  = flag_ff | sat_r.clip;
            state_in = ST_H_MUL;
         end
         ST_H_MUL: begin
            prod_in  = acc_ff * delta_ff;
            state_in = ST_H_DIV;
         end
         ST_H_DIV: begin
            neg_in           = prod_ff[2*DATA_WIDTH-1];
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(prod_mag >> FRAC_BITS);
            div_req.divisor  = DVS_W'(j_ff - k_ff);
            state_in         = ST_H_WAIT;
         end
         ST_H_WAIT: begin
            if (div_rsp.done) begin
               if (neg_ff) wide = -64'(div_rsp.quotient);
               else wide = 64'(div_rsp.quotient);
               sat_r    = pte_sat(wide);
               sum_in   = sat_r.value;
               flag_in  = flag_ff | sat_r.clip;
               j_in     = j_ff - 4'd1;
               state_in = ST_H_RD;
            end
         end
         ST_BASE: begin
            if (k_ff == 4'd0) wide = 64'(y_rd_ff) + 64'(sum_ff);
            else wide = 64'(d_rd_ff) + 64'(sum_ff);
            sat_r    = pte_sat(wide);
            sum_in   = sat_r.value;
            flag_in  = flag_ff | sat_r.clip;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_value_in = sum_ff;
               out_seg_in   = seg_ff;
               out_sat_in   = flag_ff;
               out_wrap_in  = wrap_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hint_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         out_valid_ff <= out_valid_in;
      end
      xv_ff    <= xv_in;
      k_ff     <= k_in;
      j_ff     <= j_in;
      x0_ff    <= x0_in;
      y0_ff    <= y0_in;
      xh_ff    <= xh_in;
      delta_ff <= delta_in;
      sum_ff   <= sum_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      seg_ff   <= seg_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      neg_ff   <= neg_in;
      flag_ff  <= flag_in;
      wrap_ff  <= wrap_in;
      out_value_ff <= out_value_in;
      out_seg_ff   <= out_seg_in;
      out_sat_ff   <= out_sat_in;
      out_wrap_ff  <= out_wrap_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.result_value  = out_value_ff;
   assign rsp_ch.segment_index = out_seg_ff;
   assign rsp_ch.saturated     = out_sat_ff;
   assign rsp_ch.wrapped       = out_wrap_ff;

endmodule
